>>> rtl/core/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg: shared types and constants for the skinning block
// Field widths, opcodes and the control bundle from the sequencer to the
// shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int DATA_W         = 32;
    localparam int BONE_W         = 7;
    localparam int ELEM_W         = 4;
    localparam int WEIGHT_W       = 17;
    localparam int WEIGHT_FRAC    = 16;
    localparam int WORDS_PER_BONE = 12;
    localparam int NUM_ACC        = 6;
    localparam int ACC_W          = 64;

    // request opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    typedef logic [2:0][DATA_W-1:0]         t_vec3;
    typedef logic [NUM_ACC-1:0][DATA_W-1:0] t_res6;

    // one cycle's worth of work for the MAC unit
    typedef struct packed {
        logic       mul_dot;    // matrix word times vector element
        logic       mul_wgt;    // finished row value times weight
        logic [1:0] col;        // vector element for mul_dot
        logic       dot_load;   // start a new dot product
        logic       dot_add;    // add product into dot product
        logic       trans_cap;  // capture translation word
        logic       fin;        // floor shift, add translation, saturate row
        logic       kind;       // 0 position, 1 normal
        logic [1:0] row;        // matrix row
        logic       vacc_add;   // add weighted row into vertex accumulator
        logic       out_load;   // hand out vertex, clear accumulators
    } t_mac_ctrl;

endpackage

>>> rtl/core/linear_blend_vertex_skinning.sv
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning: fixed-point linear blend skinning
// Bone matrix store plus one shared multiplier stepping through the six row
// dot products and weight scalings of each weight request.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready  | opcode, bone, element,
//           |           |                          | matrix word, weight, offset,
//           |           |                          | normal, last mark
//   out     | output    | o_out_valid / i_out_ready| skinned position, normal
//
// A bone word write is taken whenever the block is idle. A weight request holds
// o_in_ready low through six slots of six phases in the shared multiplier, the
// last row's weighting and the finish state, which hands out the vertex on a
// final weight, so no new request is taken before a run is through; the
// multiplier and the single read port of the bone store set this limit.
// Reset clears the sequencer, the vertex accumulators and the output valid.
// A final weight waits with o_in_ready low while an earlier vertex still sits
// in the output register.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning #(
    parameter int MAX_BONES = 128,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic [lbs_pkg::BONE_W-1:0]          i_bone_index,
    input  logic [lbs_pkg::ELEM_W-1:0]          i_element_index,
    input  logic signed [lbs_pkg::DATA_W-1:0]   i_matrix_value,
    input  logic [lbs_pkg::WEIGHT_W-1:0]        i_weight,
    input  logic signed [lbs_pkg::DATA_W-1:0]   i_offset_x,
    input  logic signed [lbs_pkg::DATA_W-1:0]   i_offset_y,
    input  logic signed [lbs_pkg::DATA_W-1:0]   i_offset_z,
    input  logic signed [lbs_pkg::DATA_W-1:0]   i_normal_x,
    input  logic signed [lbs_pkg::DATA_W-1:0]   i_normal_y,
    input  logic signed [lbs_pkg::DATA_W-1:0]   i_normal_z,
    input  logic                                i_last_weight,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [lbs_pkg::DATA_W-1:0]   o_pos_x,
    output logic signed [lbs_pkg::DATA_W-1:0]   o_pos_y,
    output logic signed [lbs_pkg::DATA_W-1:0]   o_pos_z,
    output logic signed [lbs_pkg::DATA_W-1:0]   o_nrm_x,
    output logic signed [lbs_pkg::DATA_W-1:0]   o_nrm_y,
    output logic signed [lbs_pkg::DATA_W-1:0]   o_nrm_z
);
    import lbs_pkg::*;

    localparam logic [31:0] MAX_BONES_U = 32'(MAX_BONES);

    logic              in_accept;
    logic              start;
    logic              mem_we;
    logic              seq_idle;
    logic              rd_en;
    logic [ELEM_W-1:0] rd_elem;
    logic [DATA_W-1:0] mat_word;
    logic              out_busy;
    t_mac_ctrl         ctrl;
    t_res6             result;

    logic [BONE_W-1:0]   r_bone;
    logic                r_bone_ok;
    logic [WEIGHT_W-1:0] r_weight;
    t_vec3               r_offset;
    t_vec3               r_normal;
    t_res6               r_out;
    logic                r_out_valid;

    // request handshake
    always_comb begin
        o_in_ready = seq_idle;
        in_accept  = i_in_valid && o_in_ready;
        start      = in_accept && (i_opcode == OP_WEIGHT);
        mem_we     = in_accept && (i_opcode == OP_WRITE);
        out_busy   = r_out_valid && !i_out_ready;
    end

    // hold the weight request for the whole run
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_bone    <= i_bone_index;
            r_bone_ok <= 32'(i_bone_index) < MAX_BONES_U;
            r_weight  <= i_weight;
            r_offset  <= {i_offset_z, i_offset_y, i_offset_x};
            r_normal  <= {i_normal_z, i_normal_y, i_normal_x};
        end
    end

    lbs_bone_mem #(
        .MAX_BONES (MAX_BONES)
    ) u_bone_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_bone (i_bone_index),
        .i_wr_elem (i_element_index),
        .i_wr_data (i_matrix_value),
        .i_re      (rd_en),
        .i_rd_bone (r_bone),
        .i_rd_elem (rd_elem),
        .o_rd_data (mat_word)
    );

    lbs_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_last     (i_last_weight),
        .i_out_busy (out_busy),
        .o_idle     (seq_idle),
        .o_rd_en    (rd_en),
        .o_rd_elem  (rd_elem),
        .o_ctrl     (ctrl)
    );

    lbs_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_mat_word (mat_word),
        .i_bone_ok  (r_bone_ok),
        .i_offset   (r_offset),
        .i_normal   (r_normal),
        .i_weight   (r_weight),
        .o_result   (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = $signed(r_out[0]);
    assign o_pos_y     = $signed(r_out[1]);
    assign o_pos_z     = $signed(r_out[2]);
    assign o_nrm_x     = $signed(r_out[3]);
    assign o_nrm_y     = $signed(r_out[4]);
    assign o_nrm_z     = $signed(r_out[5]);

    // a weight request keeps the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !o_in_ready)
        else $error("ready during a weight run");

    // a handed-out vertex is presented on the next cycle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |=> o_out_valid)
        else $error("vertex loaded but not presented");

    // a stalled vertex stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_out)))
        else $error("vertex changed while stalled");

endmodule

>>> rtl/core/lbs_bone_mem.sv
// ----------------------------------------------------------------------------
// lbs_bone_mem: bone matrix store
// Twelve 32-bit words per bone, one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lbs_bone_mem #(
    parameter int MAX_BONES = 128
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [lbs_pkg::BONE_W-1:0]  i_wr_bone,
    input  logic [lbs_pkg::ELEM_W-1:0]  i_wr_elem,
    input  logic [lbs_pkg::DATA_W-1:0]  i_wr_data,
    input  logic                        i_re,
    input  logic [lbs_pkg::BONE_W-1:0]  i_rd_bone,
    input  logic [lbs_pkg::ELEM_W-1:0]  i_rd_elem,
    output logic [lbs_pkg::DATA_W-1:0]  o_rd_data
);
    import lbs_pkg::*;

    localparam int DEPTH  = MAX_BONES * WORDS_PER_BONE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CALC_W = (ADDR_W > BONE_W + ELEM_W) ? ADDR_W : BONE_W + ELEM_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [CALC_W-1:0] wr_addr;
    logic [CALC_W-1:0] rd_addr;
    logic              wr_ok;

    // bone * 12 + element
    function automatic logic [CALC_W-1:0] word_addr(input logic [BONE_W-1:0] b,
                                                    input logic [ELEM_W-1:0] e);
        logic [CALC_W-1:0] bw;
        bw = CALC_W'(b);
        return (bw << 3) + (bw << 2) + CALC_W'(e);
    endfunction

    always_comb begin
        wr_addr = word_addr(i_wr_bone, i_wr_elem);
        rd_addr = word_addr(i_rd_bone, i_rd_elem);
        wr_ok   = (CALC_W'(i_wr_bone) < CALC_W'(MAX_BONES)) &&
                  (i_wr_elem < ELEM_W'(WORDS_PER_BONE));
    end

    // write port; out-of-range words are dropped
    always_ff @(posedge i_clk) begin
        if (i_we && wr_ok) begin
            mem[wr_addr[ADDR_W-1:0]] <= i_wr_data;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= mem[rd_addr[ADDR_W-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/lbs_mac.sv
// ----------------------------------------------------------------------------
// lbs_mac: shared multiply-accumulate unit
// One 32x32 multiplier with a product register, a dot product accumulator,
// row finish (floor shift, translation, saturation) and the six vertex
// accumulators.
// ----------------------------------------------------------------------------
module lbs_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lbs_pkg::t_mac_ctrl           i_ctrl,
    input  logic [lbs_pkg::DATA_W-1:0]   i_mat_word,
    input  logic                         i_bone_ok,
    input  lbs_pkg::t_vec3               i_offset,
    input  lbs_pkg::t_vec3               i_normal,
    input  logic [lbs_pkg::WEIGHT_W-1:0] i_weight,
    output lbs_pkg::t_res6               o_result
);
    import lbs_pkg::*;

    localparam int PROD_W    = 2 * DATA_W;
    localparam int DOT_W     = 2 * DATA_W + 2;
    localparam int ACC_IDX_W = $clog2(NUM_ACC);

    logic signed [DATA_W-1:0]    mat;
    logic signed [DATA_W-1:0]    vec_elem;
    logic signed [DATA_W-1:0]    mul_a;
    logic signed [DATA_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]    prod_full;
    logic signed [DOT_W-1:0]     prod_ext;
    logic signed [DOT_W-1:0]     row_sum;
    logic signed [ACC_W-1:0]     addend;
    logic signed [ACC_W:0]       acc_sum;
    logic signed [ACC_W-1:0]     acc_next;

    logic signed [PROD_W-1:0]    r_prod;
    logic signed [DOT_W-1:0]     r_dot;
    logic signed [DATA_W-1:0]    r_trans;
    logic signed [DATA_W-1:0]    r_row;
    logic [ACC_IDX_W-1:0]        r_wtgt;
    logic signed [ACC_W-1:0]     r_acc [NUM_ACC];

    function automatic logic signed [DATA_W-1:0] sat_dot(input logic signed [DOT_W-1:0] v);
        logic signed [DOT_W-1:0] hi;
        logic signed [DOT_W-1:0] lo;
        hi = DOT_W'($signed({1'b0, {(DATA_W-1){1'b1}}}));
        lo = DOT_W'($signed({1'b1, {(DATA_W-1){1'b0}}}));
        if (v > hi) begin
            return hi[DATA_W-1:0];
        end else if (v < lo) begin
            return lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'($signed({1'b0, {(DATA_W-1){1'b1}}}));
        lo = ACC_W'($signed({1'b1, {(DATA_W-1){1'b0}}}));
        if (v > hi) begin
            return hi[DATA_W-1:0];
        end else if (v < lo) begin
            return lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    // operand select and the shared multiplier
    always_comb begin
        mat       = i_bone_ok ? $signed(i_mat_word) : '0;
        vec_elem  = i_ctrl.kind ? $signed(i_normal[i_ctrl.col])
                                : $signed(i_offset[i_ctrl.col]);
        mul_a     = i_ctrl.mul_wgt ? r_row : mat;
        mul_b     = i_ctrl.mul_wgt ? $signed(DATA_W'(i_weight)) : vec_elem;
        prod_full = mul_a * mul_b;
        prod_ext  = DOT_W'(r_prod);
        row_sum   = (r_dot >>> FRAC_BITS) + DOT_W'(r_trans);
    end

    // weighted row into its accumulator, saturating at the 64-bit limits
    always_comb begin
        addend  = r_prod >>> WEIGHT_FRAC;
        acc_sum = {r_acc[r_wtgt][ACC_W-1], r_acc[r_wtgt]} + {addend[ACC_W-1], addend};
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                      : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    // product, dot product and row datapath
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_dot || i_ctrl.mul_wgt) begin
            r_prod <= prod_full;
        end
        if (i_ctrl.dot_load) begin
            r_dot <= prod_ext;
        end else if (i_ctrl.dot_add) begin
            r_dot <= r_dot + prod_ext;
        end
        if (i_ctrl.trans_cap) begin
            r_trans <= i_ctrl.kind ? '0 : mat;
        end
        if (i_ctrl.fin) begin
            r_row  <= sat_dot(row_sum);
            r_wtgt <= i_ctrl.kind ? ACC_IDX_W'(3) + ACC_IDX_W'(i_ctrl.row)
                                  : ACC_IDX_W'(i_ctrl.row);
        end
    end

    // vertex accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.out_load) begin
            for (int k = 0; k < NUM_ACC; k++) begin
                r_acc[k] <= '0;
            end
        end else if (i_ctrl.vacc_add) begin
            r_acc[r_wtgt] <= acc_next;
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_ACC; k++) begin
            o_result[k] = sat_acc(r_acc[k]);
        end
    end

endmodule

>>> rtl/core/lbs_seq.sv
// ----------------------------------------------------------------------------
// lbs_seq: skinning sequencer
// Walks six dot products (position and normal per row) in six-phase slots;
// the weight multiply and accumulate of each row ride in the first two phases of the
// following slot.
// ----------------------------------------------------------------------------
module lbs_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_last,
    input  logic                        i_out_busy,
    output logic                        o_idle,
    output logic                        o_rd_en,
    output logic [lbs_pkg::ELEM_W-1:0]  o_rd_elem,
    output lbs_pkg::t_mac_ctrl          o_ctrl
);
    import lbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // slot phases
    localparam logic [2:0] PH_WMUL  = 3'd0;  // weight multiply of previous row
    localparam logic [2:0] PH_WADD  = 3'd1;  // accumulate previous row
    localparam logic [2:0] PH_LOAD  = 3'd2;  // first product into dot product
    localparam logic [2:0] PH_LRD   = 3'd3;  // translation read, last multiply
    localparam logic [2:0] PH_TRANS = 3'd4;  // translation capture
    localparam logic [2:0] PH_FIN   = 3'd5;  // row finish
    localparam logic [2:0] DOT_END  = 3'(NUM_ACC);
    localparam logic [1:0] TRANS_COL = 2'd3;

    t_state     r_state, n_state;
    logic [2:0] r_dot, n_dot;
    logic [2:0] r_ph, n_ph;
    logic       r_last, n_last;
    logic       in_dot;
    logic       has_prev;

    // decode
    always_comb begin
        in_dot   = (r_state == S_RUN) && (r_dot != DOT_END);
        has_prev = (r_state == S_RUN) && (r_dot != 3'd0);

        o_ctrl           = '0;
        o_ctrl.kind      = r_dot[0];
        o_ctrl.row       = r_dot[2:1];
        o_ctrl.col       = 2'(r_ph - 3'd1);
        o_ctrl.mul_dot   = in_dot && (r_ph inside {[PH_WADD:PH_LRD]});
        o_ctrl.dot_load  = in_dot && (r_ph == PH_LOAD);
        o_ctrl.dot_add   = in_dot && (r_ph inside {[PH_LRD:PH_TRANS]});
        o_ctrl.trans_cap = in_dot && (r_ph == PH_TRANS);
        o_ctrl.fin       = in_dot && (r_ph == PH_FIN);
        o_ctrl.mul_wgt   = has_prev && (r_ph == PH_WMUL);
        o_ctrl.vacc_add  = has_prev && (r_ph == PH_WADD);
        o_ctrl.out_load  = (r_state == S_FIN) && r_last && !i_out_busy;

        o_rd_en   = in_dot && (r_ph <= PH_LRD);
        o_rd_elem = {r_dot[2:1], r_ph[1:0]};
        o_idle    = (r_state == S_IDLE);
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_dot   = r_dot;
        n_ph    = r_ph;
        n_last  = r_last;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_dot   = 3'd0;
                    n_ph    = PH_WMUL;
                    n_last  = i_last;
                end
            end
            S_RUN: begin
                if ((r_dot == DOT_END) && (r_ph == PH_WADD)) begin
                    n_state = S_FIN;
                end else if (r_ph == PH_FIN) begin
                    n_ph  = PH_WMUL;
                    n_dot = r_dot + 3'd1;
                end else begin
                    n_ph = r_ph + 3'd1;
                end
            end
            S_FIN: begin
                if (!r_last || !i_out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dot   <= 3'd0;
            r_ph    <= PH_WMUL;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dot   <= n_dot;
            r_ph    <= n_ph;
            r_last  <= n_last;
        end
    end

    // the multiplier serves one user per cycle
    a_mul_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctrl.mul_dot && o_ctrl.mul_wgt))
        else $error("multiplier claimed twice");

    // a finished row is weighted in the very next cycle
    a_fin_wgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.fin |=> o_ctrl.mul_wgt)
        else $error("row finished without weight multiply");

    // translation capture sees the word read for column three
    a_trans_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.trans_cap |-> $past(o_rd_en && (o_rd_elem[1:0] == TRANS_COL)))
        else $error("translation captured without its read");

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: linear_blend_vertex_skinning
// Loads bone matrices through write requests and sends skinning weights,
// predicts every skinned vertex with exact Q16.16 arithmetic and compares
// each field of every vertex handed out. The sender runs in random bursts
// and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lbs_pkg::*;

    localparam int MAX_BONES       = 128;
    localparam int FRAC_BITS       = 16;
    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int TARGET_REQUESTS = 1300;
    localparam int DRAIN_CYCLES    = 100;
    localparam int TIMEOUT_NS      = 10_000_000;
    localparam int STORE_WORDS     = MAX_BONES * WORDS_PER_BONE;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

    // wide enough for three full products and their sum
    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic                opcode;
        logic [BONE_W-1:0]   bone;
        logic [ELEM_W-1:0]   elem;
        logic [DATA_W-1:0]   mval;
        logic [WEIGHT_W-1:0] weight;
        t_vec3               offset;
        t_vec3               normal;
        logic                last;
    } t_skin_req;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_HOLD} t_stall;

    // DUT ports
    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_in_valid      = 1'b0;
    logic                     o_in_ready;
    logic                     i_opcode        = 1'b0;
    logic [BONE_W-1:0]        i_bone_index    = '0;
    logic [ELEM_W-1:0]        i_element_index = '0;
    logic signed [DATA_W-1:0] i_matrix_value  = '0;
    logic [WEIGHT_W-1:0]      i_weight        = '0;
    logic signed [DATA_W-1:0] i_offset_x      = '0;
    logic signed [DATA_W-1:0] i_offset_y      = '0;
    logic signed [DATA_W-1:0] i_offset_z      = '0;
    logic signed [DATA_W-1:0] i_normal_x      = '0;
    logic signed [DATA_W-1:0] i_normal_y      = '0;
    logic signed [DATA_W-1:0] i_normal_z      = '0;
    logic                     i_last_weight   = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready     = 1'b0;
    logic signed [DATA_W-1:0] o_pos_x;
    logic signed [DATA_W-1:0] o_pos_y;
    logic signed [DATA_W-1:0] o_pos_z;
    logic signed [DATA_W-1:0] o_nrm_x;
    logic signed [DATA_W-1:0] o_nrm_y;
    logic signed [DATA_W-1:0] o_nrm_z;

    // predicted block state
    logic signed [DATA_W-1:0] bone_words [STORE_WORDS];
    bit                       word_written [STORE_WORDS];
    bit                       bone_ready [MAX_BONES];
    int                       ready_bones [$];
    t_wide                    vertex_sums [NUM_ACC];
    t_res6                    vertex_q [$];

    string field_names [NUM_ACC] = '{"pos_x", "pos_y", "pos_z", "nrm_x", "nrm_y", "nrm_z"};

    int     fail_count    = 0;
    int     request_count = 0;
    int     burst_left    = 0;
    t_stall stall_mode    = RX_OPEN;
    int     stall_span    = 0;
    logic [2:0] stall_tick = '0;

    linear_blend_vertex_skinning #(
        .MAX_BONES(MAX_BONES),
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_bone_index   (i_bone_index),
        .i_element_index(i_element_index),
        .i_matrix_value (i_matrix_value),
        .i_weight       (i_weight),
        .i_offset_x     (i_offset_x),
        .i_offset_y     (i_offset_y),
        .i_offset_z     (i_offset_z),
        .i_normal_x     (i_normal_x),
        .i_normal_y     (i_normal_y),
        .i_normal_z     (i_normal_z),
        .i_last_weight  (i_last_weight),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_nrm_x        (o_nrm_x),
        .o_nrm_y        (o_nrm_y),
        .o_nrm_z        (o_nrm_z)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // fixed-point helpers
    // ------------------------------------------------------------------------
    function automatic t_wide widen(input logic signed [DATA_W-1:0] v);
        return v;
    endfunction

    function automatic t_wide clamp32(input t_wide v);
        if (v > 128'sh7FFF_FFFF) return 128'sh7FFF_FFFF;
        if (v < -128'sh8000_0000) return -128'sh8000_0000;
        return v;
    endfunction

    function automatic t_wide clamp64(input t_wide v);
        if (v > 128'sh7FFF_FFFF_FFFF_FFFF) return 128'sh7FFF_FFFF_FFFF_FFFF;
        if (v < -128'sh8000_0000_0000_0000) return -128'sh8000_0000_0000_0000;
        return v;
    endfunction

    function automatic t_vec3 vec3(input logic signed [DATA_W-1:0] x,
                                   input logic signed [DATA_W-1:0] y,
                                   input logic signed [DATA_W-1:0] z);
        t_vec3 v;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // skinning predictor: updates the bone store or accumulates one weight,
    // queues the finished vertex on the last mark
    // ------------------------------------------------------------------------
    task automatic skin_predict(input t_skin_req r);
        int    base;
        int    row;
        int    k;
        bit    full;
        t_wide m [WORDS_PER_BONE];
        t_wide dot_p;
        t_wide dot_n;
        t_wide row_p;
        t_wide row_n;
        t_wide wgt;
        t_wide s;
        t_res6 vtx;
        base = int'(r.bone) * WORDS_PER_BONE;
        if (r.opcode == OP_WRITE) begin
            // words past eleven are dropped, last mark means nothing here
            if (r.elem < WORDS_PER_BONE && r.bone < MAX_BONES) begin
                bone_words[base + r.elem]   = r.mval;
                word_written[base + r.elem] = 1'b1;
                full = 1'b1;
                for (k = 0; k < WORDS_PER_BONE; k++) full &= word_written[base + k];
                if (full && !bone_ready[r.bone]) begin
                    bone_ready[r.bone] = 1'b1;
                    ready_bones.push_back(int'(r.bone));
                end
            end
            return;
        end

        for (k = 0; k < WORDS_PER_BONE; k++)
            m[k] = (r.bone < MAX_BONES) ? widen(bone_words[base + k]) : t_wide'(0);
        wgt = r.weight;

        for (row = 0; row < 3; row++) begin
            dot_p = 0;
            dot_n = 0;
            for (k = 0; k < 3; k++) begin
                dot_p += m[row * 4 + k] * widen(r.offset[k]);
                dot_n += m[row * 4 + k] * widen(r.normal[k]);
            end
            row_p = clamp32((dot_p >>> FRAC_BITS) + m[row * 4 + 3]);
            row_n = clamp32(dot_n >>> FRAC_BITS);
            vertex_sums[row]     = clamp64(vertex_sums[row] + ((row_p * wgt) >>> WEIGHT_FRAC));
            vertex_sums[row + 3] = clamp64(vertex_sums[row + 3] +
                                           ((row_n * wgt) >>> WEIGHT_FRAC));
        end

        if (r.last) begin
            for (k = 0; k < NUM_ACC; k++) begin
                s      = clamp32(vertex_sums[k]);
                vtx[k] = s[DATA_W-1:0];
                vertex_sums[k] = 0;
            end
            vertex_q.push_back(vtx);
        end
    endtask

    // ------------------------------------------------------------------------
    // random content
    // ------------------------------------------------------------------------
    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return int'($urandom_range(0, 262143)) - 131072;
            4, 5:       return int'($urandom_range(0, 33554431)) - 16777216;
            6, 7:       return $urandom;
            8: begin
                case ($urandom_range(0, 5))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return 0;
                    3:       return -1;
                    4:       return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            default:    return int'($urandom_range(0, 2097151)) - 1048576;
        endcase
    endfunction

    function automatic t_vec3 rand_vec3();
        return vec3(rand_word(), rand_word(), rand_word());
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 65536;
            2:       return 131071;
            3, 4:    return $urandom_range(0, 131071);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    // every field random; callers overwrite the ones that matter
    function automatic t_skin_req noise_request();
        t_skin_req r;
        r.opcode = $urandom;
        r.bone   = $urandom;
        r.elem   = $urandom;
        r.mval   = $urandom;
        r.weight = $urandom;
        r.offset = vec3($urandom, $urandom, $urandom);
        r.normal = vec3($urandom, $urandom, $urandom);
        r.last   = $urandom;
        return r;
    endfunction

    function automatic logic [BONE_W-1:0] pick_bone();
        return ready_bones[$urandom_range(0, ready_bones.size() - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // request sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------------
    task automatic send_request(input t_skin_req r);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_opcode        <= r.opcode;
        i_bone_index    <= r.bone;
        i_element_index <= r.elem;
        i_matrix_value  <= r.mval;
        i_weight        <= r.weight;
        i_offset_x      <= r.offset[0];
        i_offset_y      <= r.offset[1];
        i_offset_z      <= r.offset[2];
        i_normal_x      <= r.normal[0];
        i_normal_y      <= r.normal[1];
        i_normal_z      <= r.normal[2];
        i_last_weight   <= r.last;
        do @(posedge i_clk); while (!o_in_ready);
        skin_predict(r);
        if (r.opcode == OP_WEIGHT || r.elem < WORDS_PER_BONE) request_count++;
    endtask

    task automatic write_word(input logic [BONE_W-1:0] bone, input logic [ELEM_W-1:0] elem,
                              input logic signed [DATA_W-1:0] value);
        t_skin_req r;
        r        = noise_request();
        r.opcode = OP_WRITE;
        r.bone   = bone;
        r.elem   = elem;
        r.mval   = value;
        send_request(r);
    endtask

    task automatic send_weight(input logic [BONE_W-1:0] bone, input logic [WEIGHT_W-1:0] w,
                               input t_vec3 off, input t_vec3 nrm, input logic last);
        t_skin_req r;
        r        = noise_request();
        r.opcode = OP_WEIGHT;
        r.bone   = bone;
        r.weight = w;
        r.offset = off;
        r.normal = nrm;
        r.last   = last;
        send_request(r);
    endtask

    task automatic load_bone(input logic [BONE_W-1:0] bone);
        int k;
        for (k = 0; k < WORDS_PER_BONE; k++) write_word(bone, k, rand_word());
    endtask

    task automatic send_vertex(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_weight(pick_bone(), rand_weight(), rand_vec3(), rand_vec3(), i == n - 1);
    endtask

    // ------------------------------------------------------------------------
    // receiver: stalls in spans of open, random, fixed-pattern or held-off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 3'd1;
        if (stall_span == 0) begin
            stall_mode <= t_stall'($urandom_range(0, 3));
            stall_span <= $urandom_range(8, 120);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            RX_OPEN:    i_out_ready <= 1'b1;
            RX_RANDOM:  i_out_ready <= 1'($urandom_range(0, 1));
            RX_PATTERN: i_out_ready <= (stall_tick < 3'd3);
            default:    i_out_ready <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------------
    // vertex checker: oldest expectation against each vertex handed out
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res6 got;
        t_res6 want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_nrm_z, o_nrm_y, o_nrm_x, o_pos_z, o_pos_y, o_pos_x};
            if (vertex_q.size() == 0) begin
                $error("vertex handed out with none pending");
                fail_count++;
            end else begin
                want = vertex_q.pop_front();
                for (int k = 0; k < NUM_ACC; k++) begin
                    if (got[k] !== want[k]) begin
                        $error("%s: expected %0d, got %0d", field_names[k],
                               $signed(want[k]), $signed(got[k]));
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // identity rotation with a translation at bone 0, saturating extremes at the top index
    task automatic test_bone_loading();
        int k;
        int row;
        int col;
        for (k = 0; k < WORDS_PER_BONE; k++) begin
            row = k / 4;
            col = k % 4;
            if (col == 3)
                write_word(0, k, (row == 0) ? 98304 : (row == 1) ? -131072 : 16384);
            else
                write_word(0, k, (row == col) ? Q_ONE : 0);
        end
        for (k = 0; k < WORDS_PER_BONE; k++) begin
            row = k / 4;
            if (row == 0)      write_word(MAX_BONES - 1, k, Q_MAX);
            else if (row == 1) write_word(MAX_BONES - 1, k, Q_MIN);
            else               write_word(MAX_BONES - 1, k, (k == 8) ? Q_MAX :
                                                            (k == 9) ? Q_MIN :
                                                            (k == 10) ? -1 : 0);
        end
    endtask

    // element index past eleven must leave the store alone
    task automatic test_ignored_writes();
        int k;
        for (k = WORDS_PER_BONE; k < 16; k++) write_word(0, k, rand_word());
        send_weight(0, 65536, rand_vec3(), rand_vec3(), 1'b1);
    endtask

    task automatic test_corner_weights();
        // vertex with a zero weight
        send_weight(0, 0, rand_vec3(), rand_vec3(), 1'b1);
        send_weight(0, 65536, vec3(Q_ONE, 2 * Q_ONE, -3 * Q_ONE), vec3(0, Q_ONE, 0), 1'b1);
        // saturation on the first two rows, weight above one
        send_weight(MAX_BONES - 1, 131071, vec3(Q_MAX, Q_MAX, Q_MAX),
                    vec3(Q_MAX, Q_MAX, Q_MAX), 1'b1);
        send_weight(MAX_BONES - 1, 65536, vec3(Q_MIN, Q_MIN, Q_MIN),
                    vec3(Q_MIN, Q_MIN, Q_MIN), 1'b1);
        // floor rounding of tiny negative values
        send_weight(MAX_BONES - 1, 1, vec3(-1, -1, -1), vec3(-1, 0, 1), 1'b1);
        // two-bone blend
        send_weight(0, 32768, rand_vec3(), rand_vec3(), 1'b0);
        send_weight(MAX_BONES - 1, 32768, rand_vec3(), rand_vec3(), 1'b1);
        // output saturation of the vertex sum across weights
        send_weight(MAX_BONES - 1, 131071, vec3(Q_MIN, Q_MAX, 1), vec3(Q_MAX, Q_MIN, -1), 1'b0);
        send_weight(MAX_BONES - 1, 131071, vec3(Q_MIN, Q_MAX, 1), vec3(Q_MAX, Q_MIN, -1), 1'b1);
    endtask

    // mostly well-formed vertices on loaded bones, with rewrites and noise
    task automatic test_random_traffic();
        int k;
        int sel;
        for (k = 0; k < 6; k++) load_bone($urandom_range(0, MAX_BONES - 1));
        while (request_count < TARGET_REQUESTS) begin
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                send_vertex($urandom_range(1, 4));
            end else if (sel < 72) begin
                send_weight(pick_bone(), 0, rand_vec3(), rand_vec3(), 1'b1);
            end else if (sel < 80) begin
                write_word(pick_bone(), $urandom_range(0, 15), rand_word());
            end else if (sel < 86) begin
                load_bone($urandom_range(0, MAX_BONES - 1));
            end else if (sel < 93) begin
                // vertex broken up by a bone write
                send_weight(pick_bone(), rand_weight(), rand_vec3(), rand_vec3(), 1'b0);
                write_word($urandom_range(0, MAX_BONES - 1), $urandom_range(0, 15), rand_word());
                send_vertex($urandom_range(1, 2));
            end else begin
                write_word($urandom_range(0, MAX_BONES - 1), $urandom_range(12, 15),
                           rand_word());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int k = 0; k < NUM_ACC; k++) vertex_sums[k] = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bone_loading();
        test_ignored_writes();
        test_corner_weights();
        test_random_traffic();
        i_in_valid <= 1'b0;

        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("linear_blend_vertex_skinning test passed");
        else
            $display("linear_blend_vertex_skinning test failed");
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("linear_blend_vertex_skinning test failed");
        $finish;
    end

endmodule
